### hdl/ssir_pkg.sv
// Package for the sorted set insert/remove block.
// Field widths, default sizes, opcode and status codes. No dependencies.
package ssir_pkg;

   // default sizing of the list store
   localparam int NUM_LISTS_DEF   = 16;
   localparam int MAX_ENTRIES_DEF = 64;

   // fixed field widths
   localparam int LIST_ID_W = 4;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 7;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ABSENT    = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

### hdl/ssir_req_if.sv
// Request channel: opcode, list index and value with valid/ready.
// Depends on ssir_pkg.
interface ssir_req_if;
   logic                           valid;
   logic                           ready;
   ssir_pkg::opcode_type           opcode;
   logic [ssir_pkg::LIST_ID_W-1:0] list_id;
   logic [ssir_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output opcode, output list_id, output value, input ready);
   modport sink   (input valid, input opcode, input list_id, input value, output ready);
endinterface

### hdl/ssir_rsp_if.sv
// Response channel: status and resulting entry count with valid/ready.
// Depends on ssir_pkg.
interface ssir_rsp_if;
   logic                         valid;
   logic                         ready;
   ssir_pkg::status_type         status;
   logic [ssir_pkg::COUNT_W-1:0] entry_count;

   modport source (output valid, output status, output entry_count, input ready);
   modport sink   (input valid, input status, input entry_count, output ready);
endinterface

### hdl/ssir_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ssir_ram #(
   parameter int ADDR_W = 4,
   parameter int WIDTH  = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [(1 << ADDR_W)];
   logic [WIDTH-1:0] rd_data_ff;

   // write, then registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/ssir_seq.sv
// Sequencer for the sorted set: count lookup, binary search through the shared
// comparator, one-word-per-cycle shift and response register.
// Depends on ssir_pkg, ssir_req_if, ssir_rsp_if.
module ssir_seq #(
   parameter int NUM_LISTS   = ssir_pkg::NUM_LISTS_DEF,
   parameter int MAX_ENTRIES = ssir_pkg::MAX_ENTRIES_DEF,
   parameter int ID_W        = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1,
   parameter int POS_W       = $clog2(MAX_ENTRIES),
   parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   ssir_req_if.sink                       req_ch,
   ssir_rsp_if.source                     rsp_ch,
   // entry store
   output logic                           ent_we,
   output logic [ID_W+POS_W-1:0]          ent_waddr,
   output logic [ssir_pkg::VALUE_W-1:0]   ent_wdata,
   output logic [ID_W+POS_W-1:0]          ent_raddr,
   input  logic [ssir_pkg::VALUE_W-1:0]   ent_rdata,
   // count store
   output logic                           cnt_we,
   output logic [ID_W-1:0]                cnt_waddr,
   output logic [CNT_W-1:0]               cnt_wdata,
   output logic [ID_W-1:0]                cnt_raddr,
   input  logic [CNT_W-1:0]               cnt_rdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_COUNT, S_SEARCH, S_PROBE, S_SHIFT, S_RESP
   } state_type;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   state_type                    state_ff, state_in;
   ssir_pkg::opcode_type         op_ff, op_in;
   ssir_pkg::status_type         status_ff, status_in;
   logic [ID_W-1:0]              id_ff, id_in;
   logic [ssir_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [CNT_W-1:0]             lo_ff, lo_in;
   logic [CNT_W-1:0]             hi_ff, hi_in;
   logic [CNT_W-1:0]             left_ff, left_in;
   logic [POS_W-1:0]             mid_ff, mid_in;
   logic [POS_W-1:0]             src_ff, src_in;
   logic [POS_W-1:0]             last_ff, last_in;
   logic                         found_ff, found_in;
   logic                         pend_ff, pend_in;
   logic [NUM_LISTS-1:0]         present_ff, present_in;

   logic [CNT_W-1:0]             cur_count;
   logic [CNT_W-1:0]             mid_calc;
   logic                         is_insert;
   logic                         probe_lt;
   logic                         probe_eq;

   // shared comparator: stored entry against the requested value
   assign probe_lt = ent_rdata < value_ff;
   assign probe_eq = ent_rdata == value_ff;

   assign is_insert = op_ff == ssir_pkg::OP_INSERT;
   assign cur_count = present_ff[id_ff] ? cnt_rdata : '0;
   assign mid_calc  = lo_ff + ((hi_ff - lo_ff) >> 1);

   assign req_ch.ready       = state_ff == S_IDLE;
   assign rsp_ch.valid       = state_ff == S_RESP;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.entry_count = ssir_pkg::COUNT_W'(cnt_ff);

   assign cnt_raddr = ID_W'(req_ch.list_id);
   assign cnt_waddr = id_ff;

   // next state and memory control
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      status_in  = status_ff;
      id_in      = id_ff;
      value_in   = value_ff;
      cnt_in     = cnt_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      left_in    = left_ff;
      mid_in     = mid_ff;
      src_in     = src_ff;
      last_in    = last_ff;
      found_in   = found_ff;
      pend_in    = pend_ff;
      present_in = present_ff;
      ent_we     = 1'b0;
      ent_waddr  = {id_ff, src_ff};
      ent_wdata  = value_ff;
      ent_raddr  = {id_ff, src_ff};
      cnt_we     = 1'b0;
      cnt_wdata  = cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.opcode;
               id_in    = ID_W'(req_ch.list_id);
               value_in = req_ch.value;
               if (int'(req_ch.list_id) >= NUM_LISTS) begin
                  status_in = ssir_pkg::ST_ABSENT;
                  cnt_in    = '0;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_COUNT;
               end
            end
         end

         // count is back from its store: sort out the trivial cases
         S_COUNT: begin
            status_in = ssir_pkg::ST_OK;
            cnt_in    = cur_count;
            lo_in     = '0;
            hi_in     = cur_count;
            found_in  = 1'b0;
            if (!present_ff[id_ff]) begin
               if (is_insert) begin
                  ent_we            = 1'b1;
                  ent_waddr         = {id_ff, {POS_W{1'b0}}};
                  cnt_we            = 1'b1;
                  cnt_wdata         = CNT_W'(1);
                  cnt_in            = CNT_W'(1);
                  present_in[id_ff] = 1'b1;
               end else begin
                  status_in = ssir_pkg::ST_ABSENT;
                  cnt_in    = '0;
               end
               state_in = S_RESP;
            end else if (!is_insert && cur_count == '0) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SEARCH;
            end
         end

         // issue a probe, or settle the outcome once the range is empty
         S_SEARCH: begin
            pend_in = 1'b0;
            if (lo_ff < hi_ff) begin
               mid_in    = POS_W'(mid_calc);
               ent_raddr = {id_ff, POS_W'(mid_calc)};
               state_in  = S_PROBE;
            end else if (is_insert) begin
               if (found_ff) begin
                  state_in = S_RESP;
               end else if (cnt_ff >= MAX_CNT) begin
                  status_in = ssir_pkg::ST_FULL;
                  state_in  = S_RESP;
               end else begin
                  left_in  = cnt_ff - lo_ff;
                  src_in   = POS_W'(cnt_ff - CNT_W'(1));
                  state_in = S_SHIFT;
               end
            end else begin
               if (!found_ff) begin
                  status_in = ssir_pkg::ST_NOT_FOUND;
                  state_in  = S_RESP;
               end else begin
                  left_in  = cnt_ff - lo_ff - CNT_W'(1);
                  src_in   = POS_W'(lo_ff + CNT_W'(1));
                  state_in = S_SHIFT;
               end
            end
         end

         // probe data is back: narrow the range
         S_PROBE: begin
            if (probe_lt) begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else begin
               hi_in = CNT_W'(mid_ff);
            end
            if (probe_eq) begin
               found_in = 1'b1;
            end
            state_in = S_SEARCH;
         end

         // pipelined move: read one word while writing the previous one
         S_SHIFT: begin
            if (pend_ff) begin
               ent_we    = 1'b1;
               ent_waddr = {id_ff, is_insert ? last_ff + POS_W'(1) : last_ff - POS_W'(1)};
               ent_wdata = ent_rdata;
            end
            if (left_ff != '0) begin
               ent_raddr = {id_ff, src_ff};
               last_in   = src_ff;
               src_in    = is_insert ? src_ff - POS_W'(1) : src_ff + POS_W'(1);
               left_in   = left_ff - CNT_W'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (left_ff == '0 && !pend_ff) begin
               cnt_we = 1'b1;
               if (is_insert) begin
                  ent_we    = 1'b1;
                  ent_waddr = {id_ff, POS_W'(lo_ff)};
                  ent_wdata = value_ff;
                  cnt_in    = cnt_ff + CNT_W'(1);
                  cnt_wdata = cnt_ff + CNT_W'(1);
               end else begin
                  cnt_in    = cnt_ff - CNT_W'(1);
                  cnt_wdata = cnt_ff - CNT_W'(1);
               end
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, flags and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         present_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         present_ff <= present_in;
         pend_ff    <= pend_in;
      end
      op_ff     <= op_in;
      status_ff <= status_in;
      id_ff     <= id_in;
      value_ff  <= value_in;
      cnt_ff    <= cnt_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      left_ff   <= left_in;
      mid_ff    <= mid_in;
      src_ff    <= src_in;
      last_ff   <= last_in;
      found_ff  <= found_in;
   end

endmodule

### hdl/sorted_set_insert_remove.sv
// Sorted set insert/remove: NUM_LISTS ascending lists of unique 32-bit values.
//
// req_ch carries opcode (insert/remove), list_id and value; rsp_ch returns a
// status (ok, list absent, value not found, list full) and the list's entry
// count after the operation. Both channels move a request on valid && ready.
// One request is in flight at a time; req_ch.ready is high only while idle.
//
// After acceptance the block reads the count store, then runs the binary
// search, each probe a search step and a probe step (at most log2(count)+1
// probes), then, when the list changes, shifts the words that move and
// writes the new count (and on insert the new word), then raises response
// valid. Removing the first entry of a full list is the worst case; a request
// for a bad or absent list, or a remove from an empty list, skips the search.
// The response register holds its value while rsp_ch.ready is low, and no new
// request is taken until it is delivered.
//
// Synchronous reset clears list presence and the sequencer; counts of absent
// lists read as zero, so no clearing pass is needed.
// Depends on ssir_pkg, ssir_req_if, ssir_rsp_if, ssir_ram, ssir_seq.
module sorted_set_insert_remove #(
   parameter int NUM_LISTS   = ssir_pkg::NUM_LISTS_DEF,
   parameter int MAX_ENTRIES = ssir_pkg::MAX_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ssir_req_if.sink   req_ch,
   ssir_rsp_if.source rsp_ch
);

   localparam int ID_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int POS_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic                         ent_we;
   logic [ID_W+POS_W-1:0]        ent_waddr;
   logic [ssir_pkg::VALUE_W-1:0] ent_wdata;
   logic [ID_W+POS_W-1:0]        ent_raddr;
   logic [ssir_pkg::VALUE_W-1:0] ent_rdata;
   logic                         cnt_we;
   logic [ID_W-1:0]              cnt_waddr;
   logic [CNT_W-1:0]             cnt_wdata;
   logic [ID_W-1:0]              cnt_raddr;
   logic [CNT_W-1:0]             cnt_rdata;

   // sequencer
   ssir_seq #(
      .NUM_LISTS   (NUM_LISTS),
      .MAX_ENTRIES (MAX_ENTRIES),
      .ID_W        (ID_W),
      .POS_W       (POS_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .ent_we    (ent_we),
      .ent_waddr (ent_waddr),
      .ent_wdata (ent_wdata),
      .ent_raddr (ent_raddr),
      .ent_rdata (ent_rdata),
      .cnt_we    (cnt_we),
      .cnt_waddr (cnt_waddr),
      .cnt_wdata (cnt_wdata),
      .cnt_raddr (cnt_raddr),
      .cnt_rdata (cnt_rdata)
   );

   // entry store, one row of 2**POS_W words per list
   ssir_ram #(
      .ADDR_W (ID_W + POS_W),
      .WIDTH  (ssir_pkg::VALUE_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   // per-list entry counts
   ssir_ram #(
      .ADDR_W (ID_W),
      .WIDTH  (CNT_W)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

`ifndef SYNTHESIS
   // never ready for a new request while a response waits
   a_ready_vs_resp: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a response is pending");

   // after a request is accepted the block is busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("ready stayed high after acceptance");

   // a stored count never exceeds the list capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (int'(cnt_wdata) <= MAX_ENTRIES))
      else $error("count store written beyond capacity");

   // a full status always reports a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ssir_pkg::ST_FULL)
         |-> (rsp_ch.entry_count == ssir_pkg::COUNT_W'(MAX_ENTRIES)))
      else $error("full status with a wrong count");
`endif

endmodule

### tb/sorted_set_insert_remove_chk.sv
// Checker for the sorted set insert/remove block: watches both channels,
// keeps its own copy of the lists and compares each response with it.
// Depends on ssir_pkg, ssir_req_if and ssir_rsp_if.
module sorted_set_insert_remove_chk (
   input  logic clock,
   input  logic reset,
   ssir_req_if  req_mon,
   ssir_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);

   localparam int LISTS   = ssir_pkg::NUM_LISTS_DEF;
   localparam int ENTRIES = ssir_pkg::MAX_ENTRIES_DEF;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      ssir_pkg::status_type         status;
      logic [ssir_pkg::COUNT_W-1:0] entry_count;
   } set_outcome_type;

   // shadow of the list store
   logic [ssir_pkg::VALUE_W-1:0] list_vals [LISTS][ENTRIES];
   int                           list_len  [LISTS];
   bit                           list_live [LISTS];

   set_outcome_type outcomes_due[$];

   task automatic report_mismatch(string what, int got, int want);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // first slot in [0, n) whose value is not below v; n if none
   function automatic int first_not_below(int id, int n, logic [ssir_pkg::VALUE_W-1:0] v);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (list_vals[id][mid] < v) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   // apply one request to the shadow lists and return its response
   function automatic set_outcome_type apply_set_op(ssir_pkg::opcode_type op, int id,
                                                    logic [ssir_pkg::VALUE_W-1:0] v);
      set_outcome_type res;
      int n;
      int pos;
      int k;
      res.status = ssir_pkg::ST_OK;
      n = 0;
      if (id >= LISTS) begin
         res.status = ssir_pkg::ST_ABSENT;
         n = 0;
      end else if (op == ssir_pkg::OP_INSERT) begin
         n = list_len[id];
         if (!list_live[id]) begin
            list_vals[id][0] = v;
            n = 1;
            list_live[id] = 1'b1;
         end else begin
            pos = first_not_below(id, n, v);
            if (pos < n && list_vals[id][pos] == v) begin
               // duplicate, list unchanged
            end else if (n >= ENTRIES) begin
               res.status = ssir_pkg::ST_FULL;
            end else begin
               for (k = n; k > pos; k--) list_vals[id][k] = list_vals[id][k-1];
               list_vals[id][pos] = v;
               n++;
            end
         end
      end else begin
         n = list_len[id];
         if (!list_live[id]) begin
            res.status = ssir_pkg::ST_ABSENT;
            n = 0;
         end else if (n != 0) begin
            pos = first_not_below(id, n, v);
            if (pos < n && list_vals[id][pos] == v) begin
               for (k = pos; k < n - 1; k++) list_vals[id][k] = list_vals[id][k+1];
               n--;
            end else begin
               res.status = ssir_pkg::ST_NOT_FOUND;
            end
         end
      end
      if (id < LISTS) list_len[id] = n;
      res.entry_count = n[ssir_pkg::COUNT_W-1:0];
      return res;
   endfunction

   // responses are checked before new requests are predicted
   always @(posedge clock) begin
      set_outcome_type want;
      if (reset) begin
         for (int i = 0; i < LISTS; i++) begin
            list_len[i]  = 0;
            list_live[i] = 1'b0;
         end
         outcomes_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcomes_due.size() == 0) begin
               report_mismatch("response with no request outstanding",
                               int'(rsp_mon.status), -1);
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", int'(rsp_mon.status), int'(want.status));
               if (rsp_mon.entry_count !== want.entry_count)
                  report_mismatch("entry_count", int'(rsp_mon.entry_count),
                                  int'(want.entry_count));
            end
         end
         if (req_mon.valid && req_mon.ready)
            outcomes_due.push_back(apply_set_op(req_mon.opcode, int'(req_mon.list_id),
                                                req_mon.value));
      end
      pending = outcomes_due.size();
   end

endmodule

### tb/sorted_set_insert_remove_tb.sv
// Testbench top for the sorted set insert/remove block: clock, reset,
// request stimulus, response back-pressure and the final verdict.
// Depends on ssir_pkg, both channel interfaces, the block and its checker.
module sorted_set_insert_remove_tb;

   localparam int RANDOM_ITEMS = 1950;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_HOLD    = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   reqs_sent = 0;
   bit   no_gaps   = 1'b0;

   ssir_req_if req_ch ();
   ssir_rsp_if rsp_ch ();

   sorted_set_insert_remove DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sorted_set_insert_remove_chk checker_u (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle length: mostly none or short, a few long
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // values cluster near both ends so lists collide, plus fully random ones
   function automatic logic [ssir_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return $urandom_range(0, 95);
      if (r < 90) return 32'hFFFF_FFFF - $urandom_range(0, 95);
      return $urandom();
   endfunction

   // offer one request, hold it until accepted, then maybe go idle
   task automatic push_request(ssir_pkg::opcode_type op,
                               logic [ssir_pkg::LIST_ID_W-1:0] id,
                               logic [ssir_pkg::VALUE_W-1:0] v);
      int gap;
      req_ch.valid   = 1'b1;
      req_ch.opcode  = op;
      req_ch.list_id = id;
      req_ch.value   = v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      reqs_sent++;
      @(negedge clock);
      gap = no_gaps ? 0 : idle_cycles();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         req_ch.value = $urandom();
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_all_answered();
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // one run of requests in fill, drain or mixed style
   task automatic random_run(int n_items);
      int                             style;
      int                             ins_pct;
      int                             hot_pct;
      logic [ssir_pkg::LIST_ID_W-1:0] hot;
      logic [ssir_pkg::LIST_ID_W-1:0] id;
      ssir_pkg::opcode_type           op;
      style = $urandom_range(0, 2);
      hot = ssir_pkg::LIST_ID_W'($urandom_range(0, 15));
      case (style)
         0: begin ins_pct = 90; hot_pct = 90; end
         1: begin ins_pct = 15; hot_pct = 85; end
         default: begin ins_pct = 50; hot_pct = 30; end
      endcase
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat (n_items) begin
         id = ($urandom_range(0, 99) < hot_pct) ? hot
                                                : ssir_pkg::LIST_ID_W'($urandom_range(0, 15));
         op = ($urandom_range(0, 99) < ins_pct) ? ssir_pkg::OP_INSERT : ssir_pkg::OP_REMOVE;
         push_request(op, id, pick_value());
      end
      no_gaps = 1'b0;
   endtask

   // response side: ready runs and hold-offs, one long hold while busy
   initial begin : rsp_backpressure
      int  run_len;
      int  hold_len;
      bit  long_hold_done;
      long_hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         rsp_ch.ready = 1'b1;
         run_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                                : $urandom_range(30, 200);
         repeat (run_len) @(negedge clock);
         if (!long_hold_done && reqs_sent >= 400) begin
            long_hold_done = 1'b1;
            hold_len = LONG_HOLD;
         end else begin
            hold_len = idle_cycles();
         end
         if (hold_len > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (hold_len) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[sorted_set_insert_remove] ERROR");
      $finish;
   end

   initial begin : stimulus
      int  random_done;
      int  run_len;
      bit  paused;
      req_ch.valid   = 1'b0;
      req_ch.opcode  = ssir_pkg::OP_INSERT;
      req_ch.list_id = '0;
      req_ch.value   = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: absent list, create, ends, duplicate, middle insert,
      // miss, remove last and first, emptied list, empty list ops
      push_request(ssir_pkg::OP_REMOVE, 4'd3,  32'd5);
      push_request(ssir_pkg::OP_INSERT, 4'd3,  32'h0000_0000);
      push_request(ssir_pkg::OP_INSERT, 4'd3,  32'hFFFF_FFFF);
      push_request(ssir_pkg::OP_INSERT, 4'd3,  32'h0000_0000);
      push_request(ssir_pkg::OP_INSERT, 4'd3,  32'h8000_0000);
      push_request(ssir_pkg::OP_INSERT, 4'd3,  32'h0000_0001);
      push_request(ssir_pkg::OP_REMOVE, 4'd3,  32'h0000_0002);
      push_request(ssir_pkg::OP_REMOVE, 4'd3,  32'hFFFF_FFFF);
      push_request(ssir_pkg::OP_REMOVE, 4'd3,  32'h0000_0000);
      push_request(ssir_pkg::OP_REMOVE, 4'd3,  32'h8000_0000);
      push_request(ssir_pkg::OP_REMOVE, 4'd3,  32'h0000_0001);
      push_request(ssir_pkg::OP_REMOVE, 4'd3,  32'h0000_0001);
      push_request(ssir_pkg::OP_INSERT, 4'd3,  32'h0000_0007);
      push_request(ssir_pkg::OP_INSERT, 4'd12, 32'hA5A5_A5A5);
      push_request(ssir_pkg::OP_REMOVE, 4'd12, 32'h5A5A_5A5A);
      push_request(ssir_pkg::OP_INSERT, 4'd15, 32'hFFFF_FFFF);
      push_request(ssir_pkg::OP_REMOVE, 4'd0,  32'h0000_0000);
      push_request(ssir_pkg::OP_INSERT, 4'd0,  32'h7FFF_FFFF);
      wait_all_answered();

      // random runs; once in the middle the sender waits for every response
      random_done = 0;
      paused = 1'b0;
      while (random_done < RANDOM_ITEMS) begin
         run_len = $urandom_range(60, 160);
         if (run_len > RANDOM_ITEMS - random_done) run_len = RANDOM_ITEMS - random_done;
         random_run(run_len);
         random_done += run_len;
         if (!paused && random_done >= 1000) begin
            paused = 1'b1;
            wait_all_answered();
         end
      end

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[sorted_set_insert_remove] OK");
      else
         $display("[sorted_set_insert_remove] ERROR");
      $finish;
   end

endmodule

### sorted_set_insert_remove.f
hdl/ssir_pkg.sv
hdl/ssir_req_if.sv
hdl/ssir_rsp_if.sv
hdl/ssir_ram.sv
hdl/ssir_seq.sv
hdl/sorted_set_insert_remove.sv
tb/sorted_set_insert_remove_chk.sv
tb/sorted_set_insert_remove_tb.sv
